>>> hw/rtl/pdpl_pkg.sv
// Package with the shared types and constants of the press duration PIN lock.
`default_nettype none

package pdpl_pkg;

  // Number of PIN bits compared against the configured code (1 to 7).
  localparam int unsigned PinBits = 4;

  localparam int unsigned PinW     = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;

  // Press shorter than or equal to this is ignored as a bounce.
  localparam logic [TimeW-1:0] ShortPressMs   = 32'd20;
  // Press of at least this length enters a one bit.
  localparam logic [TimeW-1:0] LongPressMs    = 32'd500;
  // A correct PIN only releases the secret within this window.
  localparam logic [TimeW-1:0] ReleaseWindowMs = 32'd60000;
  localparam logic [TimeW-1:0] TimeoutReset   = 32'd10000;

  localparam logic [PinW-1:0] PinMask = PinW'((1 << PinBits) - 1);
  localparam logic [PinW-1:0] ShiftEmpty = PinW'(1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPinCode   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPinTimeout = 1'b1;

  // Operation codes of an input word.
  localparam logic OpSample = 1'b0;
  localparam logic OpArm    = 1'b1;

  typedef struct packed {
    logic             op;
    logic             pressed;
    logic [TimeW-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic release_secret;
    logic erase_secret;
    logic is_armed;
  } out_word_t;

  typedef struct packed {
    logic             armed;
    logic [TimeW-1:0] press_start;
    logic [TimeW-1:0] first_press;
    logic [PinW-1:0]  pin_shift;
  } lock_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/pdpl_step.sv
// Next-state and result logic of the PIN lock for one input word.
`default_nettype none

module pdpl_step (
  input  var pdpl_pkg::lock_state_t           cur_i,
  input  var pdpl_pkg::in_word_t              word_i,
  input  var logic [pdpl_pkg::PinW-1:0]       pin_code_i,
  input  var logic [pdpl_pkg::TimeW-1:0]      pin_timeout_i,
  output pdpl_pkg::lock_state_t               nxt_o,
  output pdpl_pkg::out_word_t                 res_o
);

  logic [pdpl_pkg::TimeW-1:0] dur;
  logic [pdpl_pkg::TimeW-1:0] since_first;
  logic [pdpl_pkg::TimeW-1:0] since_first_nxt;
  logic [pdpl_pkg::PinW-1:0]  shifted;
  logic                       released_now;

  assign dur          = word_i.now_ms - cur_i.press_start;
  assign since_first  = word_i.now_ms - cur_i.first_press;
  assign released_now = (cur_i.press_start == '0);
  assign shifted      = {cur_i.pin_shift[pdpl_pkg::PinW-2:0],
                         (dur >= pdpl_pkg::LongPressMs)};

  always_comb begin
    nxt_o               = cur_i;
    res_o               = '0;
    since_first_nxt     = '0;
    if (word_i.op == pdpl_pkg::OpArm) begin
      nxt_o.armed = 1'b1;
    end else if (!cur_i.armed) begin
      nxt_o.press_start = '0;
      nxt_o.pin_shift   = pdpl_pkg::ShiftEmpty;
    end else begin
      if (word_i.pressed == released_now) begin
        if (!word_i.pressed) begin
          // End of a press: classify it and shift in a bit.
          if (dur > pdpl_pkg::ShortPressMs) begin
            nxt_o.pin_shift = shifted;
            if (shifted > pdpl_pkg::PinMask) begin
              if ((shifted & pdpl_pkg::PinMask) == (pin_code_i & pdpl_pkg::PinMask)) begin
                res_o.release_secret = (since_first <= pdpl_pkg::ReleaseWindowMs);
              end else begin
                nxt_o.armed        = 1'b0;
                res_o.erase_secret = 1'b1;
              end
              nxt_o.first_press = '0;
              nxt_o.pin_shift   = pdpl_pkg::ShiftEmpty;
            end
          end
          nxt_o.press_start = '0;
        end else begin
          nxt_o.press_start = word_i.now_ms;
          if (cur_i.first_press == '0) begin
            nxt_o.first_press = word_i.now_ms;
          end
        end
      end
      // Timeout is judged on the first press after this word's update.
      since_first_nxt = word_i.now_ms - nxt_o.first_press;
      if (nxt_o.first_press != '0 && since_first_nxt > pin_timeout_i) begin
        nxt_o.pin_shift    = pdpl_pkg::ShiftEmpty;
        nxt_o.press_start  = '0;
        nxt_o.first_press  = '0;
        nxt_o.armed        = 1'b0;
        res_o.erase_secret = 1'b1;
      end
    end
    res_o.is_armed = nxt_o.armed;
  end

endmodule

`default_nettype wire

>>> hw/rtl/press_duration_pin_lock.sv
// Top level of the single-button PIN lock with input and result registers.
// A word accepted into the input register passes the step logic into the
// result register, from which out_word_o is driven.
// Throughput: one word per cycle while results are taken, the lock state being updated in one pass.
// While a result waits, the input register takes one more word and then
// holds in_ready_o low until the result register is emptied.
// Reset clears the lock to disarmed with an empty shifter, the PIN code to
// zero and the timeout to 10000 ms.
`default_nettype none

module press_duration_pin_lock (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  input  var logic                              in_valid_i,
  output logic                                  in_ready_o,
  input  var pdpl_pkg::in_word_t                in_word_i,
  output logic                                  out_valid_o,
  input  var logic                              out_ready_i,
  output pdpl_pkg::out_word_t                   out_word_o,
  input  var logic                              cfg_we_i,
  input  var logic [pdpl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  var logic [pdpl_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [pdpl_pkg::PinW-1:0]  pin_code_q;
  logic [pdpl_pkg::TimeW-1:0] pin_timeout_q;

  // Input stage: holds the accepted word until the step logic consumes it.
  logic               in_valid_q;
  pdpl_pkg::in_word_t in_word_q;

  // Result stage.
  logic                out_valid_q;
  pdpl_pkg::out_word_t out_word_q;

  // Lock state, updated once per consumed word.
  pdpl_pkg::lock_state_t state_q;
  pdpl_pkg::lock_state_t state_d;
  pdpl_pkg::out_word_t   res;

  logic step_fire;
  logic in_fire;

  // The step fires when a word waits and the result register is free or
  // is being emptied this cycle.
  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_code_q    <= '0;
      pin_timeout_q <= pdpl_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdpl_pkg::CfgPinCode:    pin_code_q    <= cfg_wdata_i[pdpl_pkg::PinW-1:0];
        pdpl_pkg::CfgPinTimeout: pin_timeout_q <= cfg_wdata_i[pdpl_pkg::TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_word_q <= in_word_i;
    end
  end

  pdpl_step u_step (
    .cur_i        (state_q),
    .word_i       (in_word_q),
    .pin_code_i   (pin_code_q),
    .pin_timeout_i(pin_timeout_q),
    .nxt_o        (state_d),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.armed       <= 1'b0;
      state_q.press_start <= '0;
      state_q.first_press <= '0;
      state_q.pin_shift   <= pdpl_pkg::ShiftEmpty;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_word_q <= res;
    end
  end

  // A word never both releases and erases the secret.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.release_secret && out_word_q.erase_secret))
    else $error("release and erase in the same word");

  // An erase always leaves the lock disarmed; a release leaves it armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.erase_secret) |-> !out_word_q.is_armed)
    else $error("erase left the lock armed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.release_secret) |-> out_word_q.is_armed)
    else $error("release while disarmed");

  // The reported armed flag tracks the lock state of the last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_word_q.is_armed == state_q.armed))
    else $error("reported armed flag differs from state");

  // The marker bit of the shifter is never lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pin_shift != '0)
    else $error("PIN shifter lost its marker bit");

  // A stalled result word holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_word_q)))
    else $error("result word changed while stalled");

endmodule

`default_nettype wire

>>> sim/tb_press_duration_pin_lock.sv
// Self-checking testbench of the press duration PIN lock: directed and random words.
`timescale 1ns / 100ps

module tb_press_duration_pin_lock;

  // Idle patterns of the two channels for one phase of the run.
  typedef enum logic [1:0] {
    GapNone,
    GapSend,
    GapRecv,
    GapBoth
  } gap_mode_e;

  // Length of the receiver hold-off that fills the block and stalls its input.
  localparam int unsigned HoldCycles = 80;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int unsigned SettleCycles = 8;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  pdpl_pkg::in_word_t            in_word = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  pdpl_pkg::out_word_t           out_word;
  logic                          cfg_we = 1'b0;
  logic [pdpl_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [pdpl_pkg::CfgDataW-1:0] cfg_wdata = '0;

  press_duration_pin_lock dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // The clock runs with a 10 ns period, low for the first half.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and the results that the lock must return, oldest first.
  pdpl_pkg::in_word_t  words_to_send[$];
  pdpl_pkg::out_word_t predicted_results[$];

  // Our own copy of the lock state and of its two registers.
  pdpl_pkg::lock_state_t        lock_model;
  logic [pdpl_pkg::PinW-1:0]    model_pin = '0;
  logic [pdpl_pkg::TimeW-1:0]   model_timeout = pdpl_pkg::TimeoutReset;

  gap_mode_e   gap_mode = GapNone;
  int unsigned mismatches = 0;
  int unsigned words_queued = 0;
  // The monitor sets this when the word on the input is taken; the driver clears it.
  bit          in_taken = 1'b0;
  // The stimulus process bumps hold_req; the receiver counts the hold-off by itself.
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  // Running millisecond clock of the generated button samples; it wraps like the real one.
  logic [pdpl_pkg::TimeW-1:0] stamp = '0;

  // Works out the result of one accepted word and advances the lock state.
  function automatic pdpl_pkg::out_word_t predict_lock_result(pdpl_pkg::in_word_t w);
    pdpl_pkg::out_word_t        r;
    logic [pdpl_pkg::TimeW-1:0] held;
    logic [pdpl_pkg::PinW-1:0]  shifted;
    r = '0;
    if (w.op == pdpl_pkg::OpArm) begin
      // Arming keeps whatever was entered so far; the button fields mean nothing here.
      lock_model.armed = 1'b1;
    end else if (!lock_model.armed) begin
      lock_model.press_start = '0;
      lock_model.pin_shift = pdpl_pkg::ShiftEmpty;
    end else begin
      // A zero press start reads as released, so a press stamped at zero does not count.
      if (w.pressed == (lock_model.press_start == '0)) begin
        if (!w.pressed) begin
          held = w.now_ms - lock_model.press_start;
          if (held > pdpl_pkg::ShortPressMs) begin
            shifted = {lock_model.pin_shift[pdpl_pkg::PinW-2:0],
                       held >= pdpl_pkg::LongPressMs};
            lock_model.pin_shift = shifted;
            // The marker bit has passed the top of the PIN: the code is complete.
            if (shifted > pdpl_pkg::PinMask) begin
              if ((shifted & pdpl_pkg::PinMask) == (model_pin & pdpl_pkg::PinMask)) begin
                // A correct PIN that comes too late is dropped, but the secret is kept.
                if (w.now_ms - lock_model.first_press <= pdpl_pkg::ReleaseWindowMs) begin
                  r.release_secret = 1'b1;
                end
              end else begin
                lock_model.armed = 1'b0;
                r.erase_secret = 1'b1;
              end
              lock_model.first_press = '0;
              lock_model.pin_shift = pdpl_pkg::ShiftEmpty;
            end
          end
          lock_model.press_start = '0;
        end else begin
          lock_model.press_start = w.now_ms;
          if (lock_model.first_press == '0) begin
            lock_model.first_press = w.now_ms;
          end
        end
      end
      // The timeout is checked after the press itself, with wrapping time.
      if (lock_model.first_press != '0 &&
          (w.now_ms - lock_model.first_press) > model_timeout) begin
        lock_model.pin_shift = pdpl_pkg::ShiftEmpty;
        lock_model.press_start = '0;
        lock_model.first_press = '0;
        lock_model.armed = 1'b0;
        r.erase_secret = 1'b1;
      end
    end
    r.is_armed = lock_model.armed;
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatches++;
    $display("%0t ns: %s: got %b, expected %b", $time, what, got, want);
  endtask

  function automatic bit sender_pauses();
    case (gap_mode)
      GapSend: return $urandom_range(99) < 68;
      GapBoth: return $urandom_range(99) < 20;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (gap_mode)
      GapRecv: return $urandom_range(99) < 68;
      GapBoth: return $urandom_range(99) < 20;
      default: return 1'b0;
    endcase
  endfunction

  // The driver offers the next queued word at the falling edge once the previous
  // one has been taken, and keeps a word steady until the lock accepts it.
  always @(negedge clk) begin : word_driver
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (words_to_send.size() != 0 && !sender_pauses()) begin
        in_word <= words_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, and during a requested hold-off it stays low
  // for a whole stretch so that both pipeline registers fill up.
  always @(negedge clk) begin : result_receiver
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_stalls();
    end
  end

  // The monitor predicts each accepted word first and then checks the result
  // taken at the same edge, so a fast result can never race its prediction.
  always @(posedge clk) begin : lock_monitor
    pdpl_pkg::out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(predict_lock_result(in_word));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result word with nothing predicted", 1'b1, 1'b0);
        end else begin
          want = predicted_results.pop_front();
          if (out_word.release_secret !== want.release_secret) begin
            report_mismatch("release_secret", out_word.release_secret, want.release_secret);
          end
          if (out_word.erase_secret !== want.erase_secret) begin
            report_mismatch("erase_secret", out_word.erase_secret, want.erase_secret);
          end
          if (out_word.is_armed !== want.is_armed) begin
            report_mismatch("is_armed", out_word.is_armed, want.is_armed);
          end
        end
      end
    end
  end

  task automatic add_word(input logic op, input logic pressed,
                          input logic [pdpl_pkg::TimeW-1:0] at);
    pdpl_pkg::in_word_t w;
    w.op = op;
    w.pressed = pressed;
    w.now_ms = at;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  // One press of the given length at the running clock, sometimes with a repeated
  // sample while held or after release, followed by a pause before the next one.
  task automatic key_press(input logic [pdpl_pkg::TimeW-1:0] dur);
    logic [pdpl_pkg::TimeW-1:0] pause;
    add_word(pdpl_pkg::OpSample, 1'b1, stamp);
    if ($urandom_range(3) == 0) begin
      add_word(pdpl_pkg::OpSample, 1'b1, stamp + dur / 2);
    end
    add_word(pdpl_pkg::OpSample, 1'b0, stamp + dur);
    if ($urandom_range(5) == 0) begin
      add_word(pdpl_pkg::OpSample, 1'b0, stamp + dur + 1);
    end
    // Now and then a long pause, to run into the timeout or the release window.
    pause = ($urandom_range(11) == 0) ? $urandom_range(15000, 70000) : $urandom_range(1, 900);
    stamp = stamp + dur + pause;
  endtask

  // Keys in the first bits of a code, most significant bit first, as long and
  // short presses with an occasional bounce in between.
  task automatic enter_code(input logic [pdpl_pkg::PinW-1:0] code, input int unsigned bits);
    int unsigned i;
    for (i = 0; i < bits; i++) begin
      if ($urandom_range(9) == 0) begin
        key_press($urandom_range(0, 20));
      end
      if (code[pdpl_pkg::PinBits-1-i]) begin
        key_press(($urandom_range(3) == 0) ? 500 : $urandom_range(501, 3000));
      end else begin
        case ($urandom_range(3))
          0: key_press(21);
          1: key_press(499);
          default: key_press($urandom_range(22, 498));
        endcase
      end
    end
  endtask

  // One random piece of stimulus. Most of it is an armed PIN entry with random
  // presses; the rest is loose samples, arbitrary words and jumps of the clock.
  task automatic random_burst();
    int unsigned                pick;
    int unsigned                n;
    logic [pdpl_pkg::PinW-1:0]  code;
    logic [pdpl_pkg::TimeW-1:0] at;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(7) != 0) begin
        add_word(pdpl_pkg::OpArm, 1'($urandom_range(1)), $urandom);
      end
      code = ($urandom_range(9) < 6) ? model_pin : pdpl_pkg::PinW'($urandom);
      // A few entries break off before the PIN is complete.
      enter_code(code, ($urandom_range(9) == 0) ?
                       $urandom_range(1, pdpl_pkg::PinBits - 1) : pdpl_pkg::PinBits);
    end else if (pick < 85) begin
      for (n = $urandom_range(1, 6); n != 0; n--) begin
        add_word(pdpl_pkg::OpSample, 1'($urandom_range(1)), stamp);
        stamp = stamp + $urandom_range(0, 1000);
      end
    end else if (pick < 92) begin
      at = $urandom;
      add_word(1'($urandom_range(1)), 1'($urandom_range(1)), at);
      if ($urandom_range(1) == 0) begin
        stamp = at;
      end
    end else if (pick < 97) begin
      add_word(pdpl_pkg::OpArm, 1'($urandom_range(1)), $urandom);
    end else begin
      // Land on zero, just below the wrap, or anywhere at all.
      case ($urandom_range(2))
        0: stamp = '0;
        1: stamp = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        default: stamp = $urandom;
      endcase
    end
  endtask

  task automatic write_reg(input logic [pdpl_pkg::CfgIdxW-1:0] idx,
                           input logic [pdpl_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pdpl_pkg::CfgPinCode) begin
      model_pin = data[pdpl_pkg::PinW-1:0];
    end else begin
      model_timeout = data;
    end
  endtask

  // Waits until every queued word is in and every predicted result is out.
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_phase(input logic [pdpl_pkg::PinW-1:0] pin,
                           input logic [pdpl_pkg::TimeW-1:0] limit_ms,
                           input gap_mode_e mode, input int unsigned count,
                           input bit squeeze);
    int unsigned target;
    // Upper bits of the PIN register write are random; only the low byte is kept.
    write_reg(pdpl_pkg::CfgPinCode, {24'($urandom), pin});
    write_reg(pdpl_pkg::CfgPinTimeout, limit_ms);
    gap_mode = mode;
    target = words_queued + count;
    while (words_queued < target) begin
      random_burst();
    end
    if (squeeze) begin
      @(posedge clk);
      hold_req++;
    end
    drain();
  endtask

  // Watchdog: far above the slowest legal run of the whole stimulus.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    lock_model.armed = 1'b0;
    lock_model.press_start = '0;
    lock_model.first_press = '0;
    lock_model.pin_shift = pdpl_pkg::ShiftEmpty;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the registers still at their reset values (PIN zero,
    // timeout 10000 ms). A sample while disarmed, then arming with the button
    // fields at their extremes.
    gap_mode = GapNone;
    add_word(pdpl_pkg::OpSample, 1'b1, 32'hFFFF_FFFF);
    add_word(pdpl_pkg::OpArm, 1'b1, 32'hFFFF_FFFF);
    // A press stamped at zero still reads as released, so the next pressed
    // sample starts it again. Then a press of exactly 20 ms, which is a bounce.
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd0);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd5);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd25);
    // 500 ms enters a one, 21 and 499 ms enter zeros; repeated samples are ignored.
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd30);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd530);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd600);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd621);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd700);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd1199);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd1250);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd1300);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd1400);
    // The fourth bit completes a wrong PIN, which erases the secret.
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd1800);
    // A correct all-zero PIN whose first press straddles the wrap of the clock.
    add_word(pdpl_pkg::OpArm, 1'b0, 32'd0);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'hFFFF_FFF0);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'h0000_003F);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd100);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd200);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd300);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd400);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd500);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd600);
    // A press held 1 ms past the timeout: the bit goes in, then the secret is erased.
    add_word(pdpl_pkg::OpArm, 1'b1, 32'd0);
    add_word(pdpl_pkg::OpSample, 1'b1, 32'd20000);
    add_word(pdpl_pkg::OpSample, 1'b0, 32'd30001);
    drain();

    // Random phases, each with its own registers and idle pattern.
    stamp = 32'd40000;
    run_phase(8'hA5, 32'd10000, GapNone, 300, 1'b0);
    run_phase(8'h00, 32'd0, GapSend, 150, 1'b0);
    run_phase(8'hFF, 32'hFFFF_FFFF, GapRecv, 350, 1'b0);
    run_phase(8'h5A, 32'd65000, GapBoth, 300, 1'b0);
    run_phase(8'h3C, 32'd4000, GapNone, 250, 1'b1);
    run_phase(pdpl_pkg::PinW'($urandom), $urandom_range(2000, 90000), GapRecv, 350, 1'b0);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pdpl_pkg.sv
hw/rtl/pdpl_step.sv
hw/rtl/press_duration_pin_lock.sv
sim/tb_press_duration_pin_lock.sv
